// ===== hdl/quadrature_pi_position_servo_assert.svh =====
`ifndef QUADRATURE_PI_POSITION_SERVO_ASSERT_SVH
`define QUADRATURE_PI_POSITION_SERVO_ASSERT_SVH

`ifndef SYNTHESIS
`define QPPS_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("qpps: check failed");
`define QPPS_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("qpps: check failed");
`else
`define QPPS_ASSERT_IMP(name, clk, rst_n, pre, post)
`define QPPS_ASSERT_NXT(name, clk, rst_n, pre, post)
`endif

`endif

// ===== hdl/qpps_pkg.sv =====
package qpps_pkg;

    localparam int DEF_COUNTS_PER_TURN = 2880;
    localparam int DEF_INTEG_WIDTH     = 48;
    localparam int START_COUNT         = -720;

    localparam int TARGET_W   = 10;
    localparam int POS_OUT_W  = 13;
    localparam int DUTY_W     = 16;
    localparam int PGAIN_W    = 24;
    localparam int IGAIN_W    = 24;
    localparam int STEP_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int Q_FRAC     = 16;

    localparam logic [PGAIN_W-1:0] PROP_GAIN_RST  = PGAIN_W'(3277);
    localparam logic [IGAIN_W-1:0] INTEG_GAIN_RST = IGAIN_W'(13107);
    localparam logic [STEP_W-1:0]  STEP_TIME_RST  = STEP_W'(1311);
    localparam logic [DUTY_W-1:0]  DUTY_MAX_RST   = DUTY_W'(60000);

    // shared multiplier and scaling
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int SPLIT   = 27;
    localparam int ILIM_SH = 54;
    localparam int FULL_SH = 35;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REQ_ENCODER = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_TARGET  = 2'd2;

    localparam logic [1:0] AB_01 = 2'b01;
    localparam logic [1:0] AB_10 = 2'b10;
    localparam logic [1:0] AB_11 = 2'b11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INTEG_GAIN = 2'd1,
        REG_STEP_TIME  = 2'd2,
        REG_DUTY_MAX   = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_NOP      = 3'd0,
        OP_ENC_UP   = 3'd1,
        OP_ENC_DOWN = 3'd2,
        OP_ENC_HOLD = 3'd3,
        OP_TICK     = 3'd4,
        OP_TARGET   = 3'd5
    } op_t;

    typedef struct packed {
        op_t                         op;
        logic signed [TARGET_W-1:0]  target;
    } entry_t;

endpackage

// ===== hdl/qpps_intf.sv =====
interface qpps_cmd_if
    import qpps_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic                       chan_a;
    logic                       chan_b;
    logic signed [TARGET_W-1:0] target_angle;

    modport source (output valid, output req_type, output chan_a, output chan_b,
                    output target_angle, input ready);
    modport sink (input valid, input req_type, input chan_a, input chan_b,
                  input target_angle, output ready);
endinterface

interface qpps_res_if
    import qpps_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [POS_OUT_W-1:0] position_count;
    logic [DUTY_W-1:0]           duty;
    logic                        drive_dir;

    modport source (output valid, output position_count, output duty, output drive_dir,
                    input ready);
    modport sink (input valid, input position_count, input duty, input drive_dir,
                  output ready);
endinterface

interface qpps_cfg_if
    import qpps_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/qpps_front.sv =====
module qpps_front
    import qpps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    qpps_cmd_if.sink   cmd,
    input  logic       full,
    output logic       push,
    output entry_t     push_data
);

    logic [1:0] last_ab_reg;
    logic [1:0] last_ab_next;
    logic [1:0] cur_ab;
    op_t        op;

    assign cur_ab    = {cmd.chan_a, cmd.chan_b};
    assign cmd.ready = !full;
    assign push      = cmd.valid && cmd.ready;

    always_comb
    begin
        op = OP_NOP;
        case (cmd.req_type)
            REQ_ENCODER:
            begin
                if ((last_ab_reg == AB_11 && cur_ab == AB_10) ||
                    (last_ab_reg == AB_10 && cur_ab == AB_11))
                begin
                    op = OP_ENC_DOWN;
                end
                else if ((last_ab_reg == AB_11 && cur_ab == AB_01) ||
                         (last_ab_reg == AB_01 && cur_ab == AB_11))
                begin
                    op = OP_ENC_UP;
                end
                else
                begin
                    op = OP_ENC_HOLD;
                end
            end
            REQ_TICK:   op = OP_TICK;
            REQ_TARGET: op = OP_TARGET;
            default:    op = OP_NOP;
        endcase
    end

    assign push_data.op     = op;
    assign push_data.target = cmd.target_angle;

    assign last_ab_next = (push && cmd.req_type == REQ_ENCODER) ? cur_ab : last_ab_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ab_reg <= '0;
        end
        else
        begin
            last_ab_reg <= last_ab_next;
        end
    end

endmodule

// ===== hdl/qpps_queue.sv =====
module qpps_queue
    import qpps_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   empty
);

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/qpps_back.sv =====
`include "quadrature_pi_position_servo_assert.svh"

module qpps_back
    import qpps_pkg::*;
#(
    parameter int COUNTS_PER_TURN = DEF_COUNTS_PER_TURN,
    parameter int INTEG_WIDTH     = DEF_INTEG_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    qpps_cfg_if.sink    cfg,
    qpps_res_if.source  res,
    input  entry_t      head,
    input  logic        empty,
    output logic        pop
);

    localparam int CNT_W     = $clog2((COUNTS_PER_TURN > 1024) ? COUNTS_PER_TURN : 1024) + 1;
    localparam int CNTX_W    = CNT_W + 1;
    localparam int ERR_W     = ((CNT_W > TARGET_W + 3) ? CNT_W : TARGET_W + 3) + 1;
    localparam int IW        = INTEG_WIDTH;
    localparam int INC_MAG_W = ERR_W + STEP_W;
    localparam int P_W       = ERR_W + PGAIN_W + 1;
    localparam int ITERM_W   = ILIM_SH + 1;
    localparam int S_W       = ((P_W + Q_FRAC > ITERM_W) ? P_W + Q_FRAC : ITERM_W) + 1;
    localparam int IT_W      = MUL_P_W + SPLIT;
    localparam int IMX_W     = (IW > 2 * SPLIT) ? IW : 2 * SPLIT;

    localparam logic signed [CNTX_W-1:0] CPT_X     = CNTX_W'(COUNTS_PER_TURN);
    localparam logic signed [CNTX_W-1:0] NEG_CPT_X = CNTX_W'(-COUNTS_PER_TURN);
    localparam logic signed [CNT_W-1:0]  START_POS = CNT_W'(START_COUNT);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_INC   = 12'b0000_0000_0010,
        ST_INTEG = 12'b0000_0000_0100,
        ST_PTERM = 12'b0000_0000_1000,
        ST_ILO   = 12'b0000_0001_0000,
        ST_IHI   = 12'b0000_0010_0000,
        ST_ISUM  = 12'b0000_0100_0000,
        ST_SUM   = 12'b0000_1000_0000,
        ST_MAG   = 12'b0001_0000_0000,
        ST_DLO   = 12'b0010_0000_0000,
        ST_DHI   = 12'b0100_0000_0000,
        ST_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;

    logic [PGAIN_W-1:0]        prop_gain_reg;
    logic [IGAIN_W-1:0]        integ_gain_reg;
    logic [STEP_W-1:0]         step_time_reg;
    logic [DUTY_W-1:0]         duty_max_reg;

    logic signed [CNT_W-1:0]   pos_reg;
    logic signed [CNT_W-1:0]   pos_next;
    logic [IW-1:0]             ie_reg;
    logic [IW-1:0]             ie_next;
    logic signed [TARGET_W-1:0] target_reg;
    logic signed [TARGET_W-1:0] target_next;
    logic [DUTY_W-1:0]         held_duty_reg;
    logic [DUTY_W-1:0]         held_duty_next;
    logic                      held_dir_reg;
    logic                      held_dir_next;

    logic                      out_valid_reg;
    logic signed [POS_OUT_W-1:0] res_pos_reg;
    logic [DUTY_W-1:0]         res_duty_reg;
    logic                      res_dir_reg;
    logic                      out_free;
    logic                      load_out;

    logic [ERR_W-1:0]          errmag_reg;
    logic                      errneg_reg;
    logic                      errzero_reg;
    logic [MUL_P_W-1:0]        prod_reg;
    logic [MUL_P_W-1:0]        acc_reg;
    logic [P_W-1:0]            p_reg;
    logic [IMX_W-1:0]          imag_reg;
    logic [ITERM_W-1:0]        iterm_reg;
    logic [S_W-1:0]            s_reg;
    logic [FULL_SH-1:0]        mag_reg;
    logic                      sat_reg;

    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]        mul_b;

    logic signed [CNTX_W-1:0]  pos_ext;
    logic signed [CNTX_W-1:0]  pos_step;
    logic signed [CNT_W-1:0]   pos_wrapped;
    logic signed [ERR_W-1:0]   err_full;
    logic [ERR_W-1:0]          err_abs;
    logic [IW:0]               inc_u;
    logic [IW:0]               inc_x;
    logic [IW:0]               sum_x;
    logic [IW-1:0]             ie_sat;
    logic [IW-1:0]             ie_abs;
    logic [P_W-1:0]            pm;
    logic [P_W-1:0]            p_calc;
    logic [IT_W-1:0]           acc_sum;
    logic                      big;
    logic                      over;
    logic [S_W-1:0]            pe;
    logic [S_W-1:0]            it;
    logic [S_W-1:0]            s_calc;
    logic [S_W-1:0]            s_abs;
    logic [DUTY_W-1:0]         duty_raw;
    logic [DUTY_W-1:0]         duty_calc;

    assign cfg.ready          = 1'b1;
    assign out_free           = !out_valid_reg || res.ready;
    assign res.valid          = out_valid_reg;
    assign res.position_count = res_pos_reg;
    assign res.duty           = res_duty_reg;
    assign res.drive_dir      = res_dir_reg;

    // datapath arithmetic
    always_comb
    begin
        pos_ext  = CNTX_W'(pos_reg);
        pos_step = pos_ext;
        if (head.op == OP_ENC_UP)
        begin
            pos_step = pos_ext + CNTX_W'(1);
        end
        else if (head.op == OP_ENC_DOWN)
        begin
            pos_step = pos_ext - CNTX_W'(1);
        end
        pos_wrapped = (pos_step >= CPT_X || pos_step <= NEG_CPT_X) ? '0 : pos_step[CNT_W-1:0];

        err_full = (ERR_W'(target_reg) <<< 3) - ERR_W'(pos_reg);
        err_abs  = err_full[ERR_W-1] ? (~err_full + 1'b1) : err_full;

        inc_u  = (IW + 1)'(prod_reg[INC_MAG_W-1:0]);
        inc_x  = errneg_reg ? (~inc_u + 1'b1) : inc_u;
        sum_x  = {ie_reg[IW-1], ie_reg} + inc_x;
        ie_sat = (sum_x[IW] != sum_x[IW-1]) ? {sum_x[IW], {(IW - 1){~sum_x[IW]}}}
               : sum_x[IW-1:0];
        ie_abs = ie_reg[IW-1] ? (~ie_reg + 1'b1) : ie_reg;

        pm     = P_W'(prod_reg[P_W-2:0]);
        p_calc = errneg_reg ? (~pm + 1'b1) : pm;

        acc_sum = IT_W'(acc_reg) + (IT_W'(prod_reg) << SPLIT);
        big     = (imag_reg >> ILIM_SH) != '0;
        over    = acc_sum > (IT_W'(1) << ILIM_SH);

        pe     = {{(S_W - P_W - Q_FRAC){p_reg[P_W-1]}}, p_reg, {Q_FRAC{1'b0}}};
        it     = S_W'(iterm_reg);
        s_calc = ie_reg[IW-1] ? (pe - it) : (pe + it);
        s_abs  = s_reg[S_W-1] ? (~s_reg + 1'b1) : s_reg;

        duty_raw  = acc_sum[FULL_SH+DUTY_W-1:FULL_SH];
        duty_calc = (sat_reg || duty_raw > duty_max_reg) ? duty_max_reg : duty_raw;
    end

    // sequencer and shared multiplier operands
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        ie_next        = ie_reg;
        target_next    = target_reg;
        held_duty_next = held_duty_reg;
        held_dir_next  = held_dir_reg;
        pop            = 1'b0;
        load_out       = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty && out_free)
                begin
                    pop = 1'b1;
                    case (head.op)
                        OP_ENC_UP, OP_ENC_DOWN, OP_ENC_HOLD:
                        begin
                            pos_next = pos_wrapped;
                            load_out = 1'b1;
                        end
                        OP_TARGET:
                        begin
                            target_next = head.target;
                            ie_next     = '0;
                            load_out    = 1'b1;
                        end
                        OP_TICK:
                        begin
                            state_next = ST_INC;
                        end
                        OP_NOP:
                        begin
                            load_out = 1'b1;
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_INC:
            begin
                mul_a      = MUL_A_W'(errmag_reg);
                mul_b      = MUL_B_W'(step_time_reg);
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                mul_a      = MUL_A_W'(errmag_reg);
                mul_b      = MUL_B_W'(prop_gain_reg);
                ie_next    = ie_sat;
                state_next = ST_PTERM;
            end
            ST_PTERM:
            begin
                state_next = ST_ILO;
            end
            ST_ILO:
            begin
                mul_a      = imag_reg[SPLIT-1:0];
                mul_b      = MUL_B_W'(integ_gain_reg);
                state_next = ST_IHI;
            end
            ST_IHI:
            begin
                mul_a      = imag_reg[2*SPLIT-1:SPLIT];
                mul_b      = MUL_B_W'(integ_gain_reg);
                state_next = ST_ISUM;
            end
            ST_ISUM:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                state_next = ST_DLO;
            end
            ST_DLO:
            begin
                mul_a      = mag_reg[SPLIT-1:0];
                mul_b      = MUL_B_W'(duty_max_reg);
                state_next = ST_DHI;
            end
            ST_DHI:
            begin
                mul_a      = MUL_A_W'(mag_reg[FULL_SH-1:SPLIT]);
                mul_b      = MUL_B_W'(duty_max_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the upper partial product while the result waits
                mul_a = MUL_A_W'(mag_reg[FULL_SH-1:SPLIT]);
                mul_b = MUL_B_W'(duty_max_reg);
                if (out_free)
                begin
                    held_duty_next = duty_calc;
                    if (!errzero_reg)
                    begin
                        held_dir_next = !errneg_reg;
                    end
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            pos_reg        <= START_POS;
            ie_reg         <= '0;
            target_reg     <= '0;
            held_duty_reg  <= '0;
            held_dir_reg   <= 1'b0;
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            step_time_reg  <= STEP_TIME_RST;
            duty_max_reg   <= DUTY_MAX_RST;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            ie_reg        <= ie_next;
            target_reg    <= target_next;
            held_duty_reg <= held_duty_next;
            held_dir_reg  <= held_dir_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_PROP_GAIN:  prop_gain_reg  <= cfg.data[PGAIN_W-1:0];
                    REG_INTEG_GAIN: integ_gain_reg <= cfg.data[IGAIN_W-1:0];
                    REG_STEP_TIME:  step_time_reg  <= cfg.data[STEP_W-1:0];
                    REG_DUTY_MAX:   duty_max_reg   <= cfg.data[DUTY_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
        case (state_reg)
            ST_IDLE:
            begin
                errmag_reg  <= err_abs;
                errneg_reg  <= err_full[ERR_W-1];
                errzero_reg <= (err_full == '0);
            end
            ST_PTERM:
            begin
                p_reg    <= p_calc;
                imag_reg <= IMX_W'(ie_abs);
            end
            ST_IHI, ST_DHI:
            begin
                acc_reg <= prod_reg;
            end
            ST_ISUM:
            begin
                iterm_reg <= acc_sum[ITERM_W-1:0];
                sat_reg   <= ((integ_gain_reg != '0) && big) || over;
            end
            ST_SUM:
            begin
                s_reg <= s_calc;
            end
            ST_MAG:
            begin
                mag_reg <= s_abs[FULL_SH-1:0];
                sat_reg <= sat_reg || ((s_abs >> FULL_SH) != '0);
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            res_pos_reg  <= POS_OUT_W'(pos_next);
            res_duty_reg <= held_duty_next;
            res_dir_reg  <= held_dir_next;
        end
    end

    `QPPS_ASSERT_NXT(a_done_to_idle, clk, rst_n, state_reg == ST_DONE && out_free, state_reg == ST_IDLE)
    `QPPS_ASSERT_IMP(a_pterm_after_integ, clk, rst_n, state_reg == ST_PTERM, $past(state_reg) == ST_INTEG)
    `QPPS_ASSERT_IMP(a_err_zero_flag, clk, rst_n, state_reg != ST_IDLE, errzero_reg == (errmag_reg == '0))
    `QPPS_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1, (pos_ext < CPT_X && pos_ext > NEG_CPT_X) || pos_reg == START_POS)

endmodule

// ===== hdl/quadrature_pi_position_servo.sv =====
// PI position servo with a quadrature encoder front end. Each command word is an encoder
// sample, a control tick or a new target, and each yields one result word carrying the
// encoder count, the duty of the latest tick and the drive direction. A front stage decodes
// the encoder transition and queues the command; a back stage owns all servo state. Encoder,
// target and idle words leave the back stage in the cycle after it takes them, so they stream at
// one word per cycle while the result side is ready. A control tick holds the back stage from
// ST_INC to ST_DONE: its six products (integrator increment, proportional term, two halves
// of the integral term, two halves of the duty scaling) pass in turn through one registered
// 27x24 multiplier. Configuration is always ready and takes effect at once, even mid-tick.
module quadrature_pi_position_servo
    import qpps_pkg::*;
#(
    parameter int COUNTS_PER_TURN = DEF_COUNTS_PER_TURN,
    parameter int INTEG_WIDTH     = DEF_INTEG_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    qpps_cmd_if.sink    cmd,
    qpps_cfg_if.sink    cfg,
    qpps_res_if.source  res
);

    entry_t push_data;
    entry_t head;
    logic   push;
    logic   full;
    logic   pop;
    logic   empty;

    qpps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    qpps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    qpps_back #(
        .COUNTS_PER_TURN (COUNTS_PER_TURN),
        .INTEG_WIDTH     (INTEG_WIDTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .res   (res),
        .head  (head),
        .empty (empty),
        .pop   (pop)
    );

endmodule
